// ===== rtl/core/qsc_pkg.sv =====
// Shared types, constants and functions for the Q-subchannel ISRC/MCN decoder.
package qsc_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [3:0]  LAST_POS   = 4'd11;
  localparam logic [3:0]  CRC_HI_POS = 4'd10;
  localparam logic [3:0]  CRC_END    = 4'd9;
  localparam logic [3:0]  ADR_ISRC   = 4'h3;
  localparam logic [3:0]  ADR_MCN    = 4'h2;
  localparam logic [3:0]  ISRC_LAST  = 4'd12;
  localparam logic [3:0]  MCN_LAST   = 4'd13;
  localparam logic [3:0]  ISRC_NCODE = 4'd5;
  localparam logic [6:0]  ASCII_0    = 7'd48;
  localparam logic [6:0]  ASCII_A    = 7'd65;
  localparam logic [5:0]  CODE_DMAX  = 6'd9;
  localparam logic [5:0]  CODE_AMIN  = 6'd17;
  localparam logic [5:0]  CODE_AMAX  = 6'd42;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_ISRC   = 2'd1,
    KIND_MCN    = 2'd2
  } kind_t;

  // One finished frame handed from the byte front end to the emitter.
  typedef struct packed {
    logic        ok;
    logic [3:0]  adr;
    logic [63:0] payload;  // frame byte 1 in [63:56] ... byte 8 in [7:0]
  } frame_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [6:0] code_to_ascii(input logic [5:0] c);
    logic [6:0] a;
    a = 7'd0;
    if (c <= CODE_DMAX) begin
      a = ASCII_0 + {1'b0, c};
    end else if (c >= CODE_AMIN && c <= CODE_AMAX) begin
      a = ASCII_A + {1'b0, c - CODE_AMIN};
    end
    return a;
  endfunction

endpackage

// ===== rtl/core/q_subchannel_isrc_mcn_decoder.sv =====
// Top level of the CD Q-subchannel CRC check and ISRC/MCN decoder.
//
//  channel  | dir | tdata (low bit up)                                  | tuser       | tlast
//  ---------+-----+-----------------------------------------------------+-------------+------------
//  in_      | in  | q_byte[7:0]                                         | frame_start | -
//  out_     | out | crc_ok, adr[3:0], index_value[7:0], char_code[6:0], | kind[1:0]   | last
//           |     | char_pos[3:0], all_zero, zero fill to 32 bits       |             |
//
// One byte request per cycle; the running CRC is updated in the accept cycle.
// The closing byte of a frame yields 1, 13 or 14 results, one per cycle unless out_tready
// stalls, from the output register; the next frame's bytes keep flowing meanwhile, and only
// its closing byte waits while the previous frame is still parked for the sequencer.
// Synchronous active-low reset clears counters, CRC and all valid flags.
module q_subchannel_isrc_mcn_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // q_byte
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // crc_ok, adr, index_value, char_code, char_pos, all_zero
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast
);
  import qsc_pkg::*;

  logic   frame_vld;
  logic   frame_take;
  frame_t frame;

  qsc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .frame_vld  (frame_vld),
    .frame      (frame),
    .frame_take (frame_take)
  );

  qsc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_vld  (frame_vld),
    .frame      (frame),
    .frame_take (frame_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/qsc_front.sv =====
// Byte front end: frame position, running CRC, payload capture and frame check.
module qsc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tuser,
  output logic          frame_vld,
  output qsc_pkg::frame_t frame,
  input  logic          frame_take
);
  import qsc_pkg::*;

  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  mode_r, mode_nxt;
  logic [7:0]  rcrc_hi_r, rcrc_hi_nxt;
  logic [7:0]  payload_r [8];
  logic        frame_vld_r, frame_vld_nxt;
  frame_t      frame_r, frame_nxt;

  logic [3:0]  pos;
  logic [15:0] rcrc;
  logic [63:0] pv;
  logic        acc;
  logic [3:0]  wr_idx;

  // Only a byte at the closing count (even one with frame_start) needs the frame slot to be free.
  assign in_tready = !frame_vld_r || (cnt_r != LAST_POS);
  assign acc       = in_tvalid && in_tready;
  assign frame_vld = frame_vld_r;
  assign frame     = frame_r;

  always_comb begin
    pos = in_tuser ? 4'd0 : ((cnt_r > LAST_POS) ? 4'd0 : cnt_r);
  end

  assign wr_idx = pos - 4'd1;
  assign rcrc   = {rcrc_hi_r, in_tdata};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pv[63 - 8*i -: 8] = payload_r[i];
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    mode_nxt      = mode_r;
    rcrc_hi_nxt   = rcrc_hi_r;
    frame_vld_nxt = frame_vld_r && !frame_take;
    frame_nxt     = frame_r;
    if (acc) begin
      cnt_nxt = (pos == LAST_POS) ? 4'd0 : pos + 4'd1;
      if (pos <= CRC_END) begin
        crc_nxt = crc_byte((pos == 4'd0) ? 16'h0000 : crc_r, in_tdata);
        if (pos == 4'd0) begin
          mode_nxt = in_tdata[3:0];
        end
      end else if (pos == CRC_HI_POS) begin
        rcrc_hi_nxt = in_tdata;
      end else begin
        frame_vld_nxt     = 1'b1;
        frame_nxt.ok      = (rcrc != 16'h0000) && (rcrc == ~crc_r);
        frame_nxt.adr     = mode_r;
        frame_nxt.payload = pv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 4'd0;
      crc_r       <= 16'h0000;
      mode_r      <= 4'd0;
      rcrc_hi_r   <= 8'h00;
      frame_vld_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      mode_r      <= mode_nxt;
      rcrc_hi_r   <= rcrc_hi_nxt;
      frame_vld_r <= frame_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (acc && pos >= 4'd1 && pos <= 4'd8) begin
      payload_r[wr_idx[2:0]] <= in_tdata;
    end
  end

endmodule

// ===== rtl/core/qsc_emit.sv =====
// Result sequencer: status plus ISRC or MCN characters, one per cycle when not stalled, into the output register.
module qsc_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          frame_vld,
  input  qsc_pkg::frame_t frame,
  output logic          frame_take,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata,
  output logic [1:0]    out_tuser,
  output logic          out_tlast
);
  import qsc_pkg::*;

  logic        busy_r, busy_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  last_r, last_nxt;
  logic        zero_r, zero_nxt;
  frame_t      frm_r;
  logic        ovld_r, ovld_nxt;
  logic [24:0] odata_r;
  kind_t       okind_r;
  logic        olast_r;

  logic        adv;
  logic        is_last;
  logic        is_isrc;
  logic [3:0]  ci;
  logic [6:0]  sh6, shn;
  logic [5:0]  code6;
  logic [3:0]  nib;
  logic [6:0]  ch;
  logic        ch_zero;
  kind_t       kind;
  logic [24:0] data;

  assign frame_take = !busy_r && frame_vld;
  assign adv        = busy_r && (!ovld_r || out_tready);
  assign is_last    = (idx_r == last_r);
  assign is_isrc    = (frm_r.adr == ADR_ISRC);
  assign ci         = idx_r - 4'd1;

  // Bit offsets into the payload word: 6-bit ISRC codes, then 4-bit digits.
  always_comb begin
    sh6   = 7'd58 - ({3'd0, ci} << 2) - ({3'd0, ci} << 1);
    shn   = (is_isrc ? 7'd48 : 7'd60) - ({3'd0, ci} << 2);
    code6 = 6'(frm_r.payload >> sh6);
    nib   = 4'(frm_r.payload >> shn);
    if (is_isrc && ci < ISRC_NCODE) begin
      ch = code_to_ascii(code6);
    end else begin
      ch = ASCII_0 + {3'd0, nib};
    end
    ch_zero = (ch == ASCII_0);
  end

  always_comb begin
    if (idx_r == 4'd0) begin
      kind = KIND_STATUS;
      data = {1'b0, 4'd0, 7'd0, frm_r.payload[55:48], frm_r.adr, frm_r.ok};
    end else begin
      kind = is_isrc ? KIND_ISRC : KIND_MCN;
      data = {is_last && zero_r && ch_zero, ci, ch, frm_r.payload[55:48], frm_r.adr, 1'b1};
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    last_nxt = last_r;
    zero_nxt = zero_r;
    ovld_nxt = out_tready ? 1'b0 : ovld_r;
    if (frame_take) begin
      busy_nxt = 1'b1;
      idx_nxt  = 4'd0;
      zero_nxt = 1'b1;
      if (frame.ok && frame.adr == ADR_ISRC) begin
        last_nxt = ISRC_LAST;
      end else if (frame.ok && frame.adr == ADR_MCN) begin
        last_nxt = MCN_LAST;
      end else begin
        last_nxt = 4'd0;
      end
    end else if (adv) begin
      ovld_nxt = 1'b1;
      idx_nxt  = idx_r + 4'd1;
      if (idx_r != 4'd0 && !ch_zero) begin
        zero_nxt = 1'b0;
      end
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 4'd0;
      last_r <= 4'd0;
      zero_r <= 1'b1;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      last_r <= last_nxt;
      zero_r <= zero_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      frm_r <= frame;
    end
    if (adv) begin
      odata_r <= data;
      okind_r <= kind;
      olast_r <= is_last;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {7'd0, odata_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the Q-subchannel CRC check and ISRC/MCN decoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qsc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_SHOWN  = 10;
  localparam int END_WAIT   = 40;

  typedef struct packed {
    kind_t       kind;
    logic        crc_ok;
    logic [3:0]  adr;
    logic [7:0]  index_value;
    logic [6:0]  char_code;
    logic [3:0]  char_pos;
    logic        all_zero;
    logic [6:0]  pad;
    logic        last;
  } q_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  q_subchannel_isrc_mcn_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // decoder shadow state
  logic [3:0]  frame_pos = 4'd0;
  logic [15:0] crc_acc = 16'h0000;
  logic [3:0]  adr_nib = 4'h0;
  logic [7:0]  frame_bytes[8];
  logic [15:0] rx_crc = 16'h0000;
  logic [6:0]  char_buf[13];

  q_result_t   frame_outputs[$];
  logic [7:0]  frm[12];

  int burst_left = 0;
  int bytes_sent = 0;
  int errors = 0;
  int status_seen = 0;
  int isrc_seen = 0;
  int mcn_seen = 0;
  int stall_cycles = 0;
  int rx_tick = 0;
  int rx_hold = 0;
  logic rx_level = 1'b1;

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic [6:0] isrc_char(input logic [5:0] c);
    if (c <= CODE_DMAX) return ASCII_0 + {1'b0, c};
    if (c >= CODE_AMIN && c <= CODE_AMAX) return ASCII_A + {1'b0, c - CODE_AMIN};
    return 7'd0;
  endfunction

  function automatic string show(input q_result_t r);
    return $sformatf("kind=%0d ok=%0d adr=%h idx=%h code=%h pos=%0d az=%0d pad=%h last=%0d",
                     r.kind, r.crc_ok, r.adr, r.index_value, r.char_code, r.char_pos,
                     r.all_zero, r.pad, r.last);
  endfunction

  task automatic push_result(input kind_t k, input logic ok, input logic [6:0] code,
                             input logic [3:0] p, input logic az, input logic l);
    q_result_t r;
    r.kind        = k;
    r.crc_ok      = ok;
    r.adr         = adr_nib;
    r.index_value = frame_bytes[1];
    r.char_code   = code;
    r.char_pos    = p;
    r.all_zero    = az;
    r.pad         = 7'd0;
    r.last        = l;
    frame_outputs.push_back(r);
  endtask

  task automatic push_chars(input kind_t k, input int n);
    logic all0;
    all0 = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (char_buf[i] != ASCII_0) all0 = 1'b0;
      push_result(k, 1'b1, char_buf[i], i[3:0], (i == n - 1) ? all0 : 1'b0, i == n - 1);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic s);
    logic [3:0]  p;
    logic        ok;
    logic [31:0] code_bits;
    logic [31:0] isrc_digits;
    logic [55:0] mcn_digits;
    if (s) begin
      frame_pos = 4'd0;
      crc_acc = 16'h0000;
    end
    p = frame_pos;
    frame_pos = (p == LAST_POS) ? 4'd0 : p + 4'd1;
    if (p <= CRC_END) begin
      if (p == 4'd0) begin
        crc_acc = 16'h0000;
        adr_nib = b[3:0];
      end
      if (p >= 4'd1 && p <= 4'd8) frame_bytes[3'(p - 4'd1)] = b;
      crc_acc = crc_next(crc_acc, b);
    end else if (p == CRC_HI_POS) begin
      rx_crc = {b, 8'h00};
    end else begin
      rx_crc[7:0] = b;
      // a stored CRC of zero never counts as good
      ok = (rx_crc != 16'h0000) && (rx_crc == ~crc_acc);
      if (ok && adr_nib == ADR_ISRC) begin
        push_result(KIND_STATUS, 1'b1, 7'd0, 4'd0, 1'b0, 1'b0);
        code_bits = {frame_bytes[0], frame_bytes[1], frame_bytes[2], frame_bytes[3]};
        isrc_digits = {frame_bytes[4], frame_bytes[5], frame_bytes[6], frame_bytes[7]};
        for (int i = 0; i < 5; i++) char_buf[i] = isrc_char(code_bits[31 - 6 * i -: 6]);
        for (int i = 0; i < 7; i++)
          char_buf[5 + i] = ASCII_0 + {3'b000, isrc_digits[31 - 4 * i -: 4]};
        push_chars(KIND_ISRC, ISRC_LAST);
      end else if (ok && adr_nib == ADR_MCN) begin
        push_result(KIND_STATUS, 1'b1, 7'd0, 4'd0, 1'b0, 1'b0);
        mcn_digits = {frame_bytes[0], frame_bytes[1], frame_bytes[2], frame_bytes[3],
                      frame_bytes[4], frame_bytes[5], frame_bytes[6]};
        for (int i = 0; i < 13; i++)
          char_buf[i] = ASCII_0 + {3'b000, mcn_digits[55 - 4 * i -: 4]};
        push_chars(KIND_MCN, MCN_LAST);
      end else begin
        push_result(KIND_STATUS, ok, 7'd0, 4'd0, 1'b0, 1'b1);
      end
    end
  endtask

  // one request per byte, held until accepted; bursts with random gaps
  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= s;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, s);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (frame_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic fill_frame(input logic [3:0] adr);
    frm[0] = {4'($urandom_range(0, 15)), adr};
    for (int i = 1; i < 10; i++) frm[i] = 8'($urandom_range(0, 255));
  endtask

  task automatic seal_frame(input bit corrupt);
    logic [15:0] c;
    c = 16'h0000;
    for (int i = 0; i < 10; i++) c = crc_next(c, frm[i]);
    c = ~c;
    if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
    frm[10] = c[15:8];
    frm[11] = c[7:0];
  endtask

  task automatic put_isrc_codes(input logic [5:0] c0, input logic [5:0] c1,
                                input logic [5:0] c2, input logic [5:0] c3,
                                input logic [5:0] c4);
    logic [31:0] bits;
    bits = {c0, c1, c2, c3, c4, 2'($urandom_range(0, 3))};
    {frm[1], frm[2], frm[3], frm[4]} = bits;
  endtask

  // frame_start is mandatory when the counter is off a frame boundary
  task automatic send_frame();
    logic start;
    start = (frame_pos != 4'd0) || ($urandom_range(0, 1) == 1);
    for (int i = 0; i < 12; i++) send_byte(frm[i], (i == 0) && start);
  endtask

  task automatic test_isrc_extremes();
    frm[0] = {4'h0, ADR_ISRC};
    for (int i = 1; i < 10; i++) frm[i] = 8'h00;
    seal_frame(1'b0);
    send_frame();
    fill_frame(ADR_ISRC);
    frm[0][7:4] = 4'hF;
    put_isrc_codes(6'd9, 6'd16, 6'd17, 6'd42, 6'd43);
    frm[5] = 8'h09;
    frm[6] = 8'hAF;
    seal_frame(1'b0);
    send_frame();
  endtask

  task automatic test_mcn_extremes();
    frm[0] = {4'hF, ADR_MCN};
    for (int i = 1; i < 10; i++) frm[i] = 8'hFF;
    seal_frame(1'b0);
    send_frame();
  endtask

  task automatic test_zero_stored_crc();
    logic [15:0] c8;
    logic [15:0] c;
    fill_frame(ADR_ISRC);
    c8 = 16'h0000;
    for (int i = 0; i < 8; i++) c8 = crc_next(c8, frm[i]);
    // pick bytes 8 and 9 so the inverted CRC is zero and matches a zero stored CRC
    for (int x = 0; x < 65536; x++) begin
      c = crc_next(crc_next(c8, x[15:8]), x[7:0]);
      if (c == 16'hFFFF) begin
        frm[8] = x[15:8];
        frm[9] = x[7:0];
        break;
      end
    end
    frm[10] = 8'h00;
    frm[11] = 8'h00;
    send_frame();
  endtask

  task automatic test_resync();
    for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
    fill_frame(ADR_MCN);
    seal_frame(1'b0);
    send_frame();
  endtask

  task automatic test_random_traffic(input int target);
    int sel;
    int n;
    logic [3:0] adr;
    while (bytes_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        n = $urandom_range(1, 13);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        if (sel < 50) adr = ADR_ISRC;
        else if (sel < 75) adr = ADR_MCN;
        else if (sel < 87) adr = 4'($urandom_range(0, 15));
        else adr = $urandom_range(0, 1) ? ADR_ISRC : ADR_MCN;
        fill_frame(adr);
        if ($urandom_range(0, 7) == 0) begin
          for (int i = 1; i < 9; i++) frm[i] = 8'h00;
        end
        seal_frame(sel >= 87);
        send_frame();
      end
    end
  endtask

  // receiver: cycles through always-ready, coin-flip, sparse and long-stall phases
  always @(negedge clk) begin
    rx_tick++;
    case ((rx_tick / 256) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 20);
          rx_level = ~rx_level;
        end
        rx_hold--;
        out_tready <= rx_level;
      end
    endcase
  end

  always @(posedge clk) begin : result_check
    q_result_t got;
    q_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind        = kind_t'(out_tuser);
      got.crc_ok      = out_tdata[0];
      got.adr         = out_tdata[4:1];
      got.index_value = out_tdata[12:5];
      got.char_code   = out_tdata[19:13];
      got.char_pos    = out_tdata[23:20];
      got.all_zero    = out_tdata[24];
      got.pad         = out_tdata[31:25];
      got.last        = out_tlast;
      case (got.kind)
        KIND_STATUS: status_seen++;
        KIND_ISRC:   isrc_seen++;
        default:     mcn_seen++;
      endcase
      if (frame_outputs.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) $display("unexpected result: %s", show(got));
      end else begin
        want = frame_outputs.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("q_subchannel_isrc_mcn_decoder verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) frame_bytes[i] = 8'h00;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_isrc_extremes();
    test_mcn_extremes();
    test_zero_stored_crc();
    test_resync();
    test_random_traffic(210);
    wait_drained();
    test_random_traffic(420);
    wait_drained();
    repeat (END_WAIT) @(posedge clk);
    $display("run covered %0d input bytes, %0d frame statuses, %0d ISRC chars, %0d MCN digits",
             bytes_sent, status_seen, isrc_seen, mcn_seen);
    $display("mismatches found: %0d", errors);
    if (errors == 0) begin
      $display("q_subchannel_isrc_mcn_decoder verification clean");
    end else begin
      $display("q_subchannel_isrc_mcn_decoder verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/qsc_pkg.sv
rtl/core/qsc_front.sv
rtl/core/qsc_emit.sv
rtl/core/q_subchannel_isrc_mcn_decoder.sv
bench/tb.sv
